FILE: sv/lsbse_pkg.sv
// shared types, codes and helpers for the lsb stego embed/extract block
package lsbse_pkg;

    localparam int NUM_SAMPLES = 8;
    localparam int CNT_W       = 24;
    localparam int PADDR_W     = 3;

    localparam logic [7:0] MARK_0 = 8'd85;
    localparam logic [7:0] MARK_1 = 8'd95;
    localparam logic [7:0] MARK_2 = 8'd255;

    // register index as seen on paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        FUNC_EMBED   = 2'd0,
        FUNC_MARK    = 2'd1,
        FUNC_EXTRACT = 2'd2
    } func_t;

    typedef logic [NUM_SAMPLES-1:0][7:0] sample_arr_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  payload;
        sample_arr_t sample;
    } item_t;

    typedef struct packed {
        sample_arr_t stego;
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        marker_done;
        logic        no_room;
    } result_t;

    function automatic logic [7:0] mark_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd1:    b = MARK_1;
            2'd2:    b = MARK_2;
            default: b = MARK_0;
        endcase
        return b;
    endfunction

    // sample i carries bit 7-i of the byte
    function automatic sample_arr_t hide_byte(input sample_arr_t s, input logic [7:0] b);
        sample_arr_t o;
        o = s;
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            o[i][0] = b[NUM_SAMPLES-1-i];
        end
        return o;
    endfunction

    function automatic logic [7:0] pick_byte(input sample_arr_t s);
        logic [7:0] b;
        b = '0;
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            b[NUM_SAMPLES-1-i] = s[i][0];
        end
        return b;
    endfunction

endpackage

FILE: sv/lsbse_cfg.sv
// apb register block holding the capacity register
module lsbse_cfg
    import lsbse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [CNT_W-1:0]   capacity
);

    logic [CNT_W-1:0] capacity_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (wr_en)
        begin
            capacity_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = {{(32-CNT_W){1'b0}}, capacity_reg};
        end
    end

    assign capacity = capacity_reg;

endmodule

FILE: sv/lsbse_core.sv
// embed/extract logic with byte counter, marker index and holdback state
module lsbse_core
    import lsbse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  item_t            item,
    input  logic [CNT_W-1:0] capacity,
    output result_t          res
);

    logic [CNT_W-1:0] bytes_used_reg, bytes_used_next;
    logic [1:0]       marker_index_reg, marker_index_next;
    logic [7:0]       recent0_reg, recent0_next;
    logic [7:0]       recent1_reg, recent1_next;
    logic [1:0]       recent_count_reg, recent_count_next;
    logic             end_found_reg, end_found_next;

    logic             room;
    logic [1:0]       mark_idx;
    logic [7:0]       ext_byte;

    assign room     = bytes_used_reg < capacity;
    assign mark_idx = (marker_index_reg == 2'd3) ? 2'd0 : marker_index_reg;
    assign ext_byte = pick_byte(item.sample);

    always_comb
    begin
        res                = '0;
        res.stego          = item.sample;
        bytes_used_next    = bytes_used_reg;
        marker_index_next  = marker_index_reg;
        recent0_next       = recent0_reg;
        recent1_next       = recent1_reg;
        recent_count_next  = recent_count_reg;
        end_found_next     = end_found_reg;

        case (item.func)
            FUNC_EMBED:
            begin
                if (room)
                begin
                    res.stego       = hide_byte(item.sample, item.payload);
                    bytes_used_next = bytes_used_reg + CNT_W'(1);
                end
                else
                begin
                    res.no_room = 1'b1;
                end
            end
            FUNC_MARK:
            begin
                if (room)
                begin
                    res.stego       = hide_byte(item.sample, mark_byte(mark_idx));
                    bytes_used_next = bytes_used_reg + CNT_W'(1);
                    if (mark_idx == 2'd2)
                    begin
                        res.marker_done   = 1'b1;
                        marker_index_next = 2'd0;
                    end
                    else
                    begin
                        marker_index_next = mark_idx + 2'd1;
                    end
                end
                else
                begin
                    res.no_room = 1'b1;
                end
            end
            FUNC_EXTRACT:
            begin
                if (end_found_reg)
                begin
                    res.marker_done = 1'b1;
                end
                else if (!room)
                begin
                    res.no_room = 1'b1;
                end
                else
                begin
                    bytes_used_next = bytes_used_reg + CNT_W'(1);
                    if (recent_count_reg == 2'd2)
                    begin
                        if (recent0_reg == MARK_0 && recent1_reg == MARK_1 &&
                            ext_byte == MARK_2)
                        begin
                            end_found_next  = 1'b1;
                            res.marker_done = 1'b1;
                        end
                        else
                        begin
                            res.out_byte  = recent0_reg;
                            res.out_valid = 1'b1;
                            recent0_next  = recent1_reg;
                            recent1_next  = ext_byte;
                        end
                    end
                    else if (recent_count_reg == 2'd1)
                    begin
                        recent1_next      = ext_byte;
                        recent_count_next = 2'd2;
                    end
                    else
                    begin
                        recent0_next      = ext_byte;
                        recent_count_next = 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_used_reg   <= '0;
            marker_index_reg <= '0;
            recent0_reg      <= '0;
            recent1_reg      <= '0;
            recent_count_reg <= '0;
            end_found_reg    <= 1'b0;
        end
        else if (step)
        begin
            bytes_used_reg   <= bytes_used_next;
            marker_index_reg <= marker_index_next;
            recent0_reg      <= recent0_next;
            recent1_reg      <= recent1_next;
            recent_count_reg <= recent_count_next;
            end_found_reg    <= end_found_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        recent_count_reg != 2'd3)
        else $error("holdback count out of range");

    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        marker_index_reg != 2'd3)
        else $error("marker index out of range");

    a_noroom_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.no_room |=> $stable(bytes_used_reg))
        else $error("byte counter moved without room");

    a_release_full: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.out_valid |-> recent_count_reg == 2'd2)
        else $error("byte released before holdback filled");

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        end_found_reg |=> end_found_reg)
        else $error("end marker flag cleared");

endmodule

FILE: sv/lsb_stego_embed_extract.sv
// top level: input register, embed/extract core, result register, apb port
//
//  channel   dir  transfers                               tdata / tuser
//  s_axis    in   one item per transaction                 72b samples+byte / 2b func
//  m_axis    out  one result per accepted item, in order   72b stego+byte / 3b flags
//  apb       in   capacity_bytes at byte address 0         32b
//
// an input transaction reaches m_axis through the input register and then the result
// register; the core between them computes its result combinationally
// one item per cycle while m_axis does not stall; both registers move together when
// the result register is empty or its transaction completes
// a stall on m_axis holds both registers and drops s_axis_tready once full
// rst_n clears valid flags, byte counter, marker index and holdback state
module lsb_stego_embed_extract
    import lsbse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [71:0]        s_axis_tdata,  // payload, sample_0 .. sample_7
    input  logic [1:0]         s_axis_tuser,  // func
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [71:0]        m_axis_tdata,  // stego_0 .. stego_7, out_byte
    output logic [2:0]         m_axis_tuser,  // out_valid, marker_done, no_room
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic             in_valid_reg;
    item_t            in_item_reg;
    item_t            in_item_next;
    logic             res_valid_reg;
    result_t          res_reg;
    result_t          core_res;
    logic [CNT_W-1:0] capacity;
    logic             advance;
    logic             step;

    lsbse_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    always_comb
    begin
        in_item_next.func    = func_t'(s_axis_tuser);
        in_item_next.payload = s_axis_tdata[7:0];
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            in_item_next.sample[i] = s_axis_tdata[8*i+8 +: 8];
        end
    end

    assign advance       = !res_valid_reg || m_axis_tready;
    assign step          = advance && in_valid_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    lsbse_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (in_item_reg),
        .capacity (capacity),
        .res      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload only
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item_next;
        end
        if (step)
        begin
            res_reg <= core_res;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            m_axis_tdata[8*i +: 8] = res_reg.stego[i];
        end
        m_axis_tdata[71:64] = res_reg.out_byte;
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tuser  = {res_reg.no_room, res_reg.marker_done, res_reg.out_valid};

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the lsb stego embed/extract block
module tb_top;
    import lsbse_pkg::*;

    localparam logic [1:0]         FUNC_UNUSED = 2'd3;
    localparam logic [23:0]        CAP_MAX     = 24'hFF_FFFF;
    localparam logic [PADDR_W-1:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic [1:0]      func;
        logic [7:0]      data;
        logic [7:0][7:0] smp;
    } carrier_item_t;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [71:0]        s_axis_tdata  = '0;  // payload, sample_0 .. sample_7
    logic [1:0]         s_axis_tuser  = '0;  // func
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [71:0]        m_axis_tdata;        // stego_0 .. stego_7, out_byte
    logic [2:0]         m_axis_tuser;        // out_valid, marker_done, no_room
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    lsb_stego_embed_extract u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state, matches the block after reset
    logic [23:0] cap_reg    = '0;
    logic [23:0] used_count = '0;
    logic [1:0]  mark_pos   = '0;
    logic [7:0]  held [2]   = '{8'h00, 8'h00};
    logic [1:0]  held_cnt   = '0;
    bit          end_seen   = 1'b0;

    carrier_item_t carrier_q [$];
    result_t       stego_expect_q [$];
    carrier_item_t on_bus;
    result_t       want;
    int            mismatches = 0;
    int            feed_gap   = 0;
    int            drain_gap  = 0;
    bit            feed_calm  = 1'b0;
    bit            drain_calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0][7:0] lsb_insert(input logic [7:0][7:0] s, input logic [7:0] b);
        logic [7:0][7:0] o;
        o = s;
        for (int i = 0; i < 8; i++)
        begin
            o[i][0] = b[7-i];
        end
        return o;
    endfunction

    function automatic logic [7:0] lsb_gather(input logic [7:0][7:0] s);
        logic [7:0] b;
        for (int i = 0; i < 8; i++)
        begin
            b[7-i] = s[i][0];
        end
        return b;
    endfunction

    function automatic result_t predict_stego(input carrier_item_t it);
        result_t    r;
        logic [7:0] b;
        logic [1:0] k;
        r.stego       = it.smp;
        r.out_byte    = '0;
        r.out_valid   = 1'b0;
        r.marker_done = 1'b0;
        r.no_room     = 1'b0;
        if (it.func == FUNC_UNUSED)
            return r;
        // once the marker is seen, extract is a pass-through that ignores capacity
        if (it.func == FUNC_EXTRACT && end_seen)
        begin
            r.marker_done = 1'b1;
            return r;
        end
        if (used_count >= cap_reg)
        begin
            r.no_room = 1'b1;
            return r;
        end
        used_count = used_count + 24'd1;
        case (it.func)
            FUNC_EMBED:
                r.stego = lsb_insert(it.smp, it.data);
            FUNC_MARK:
            begin
                k = (mark_pos == 2'd3) ? 2'd0 : mark_pos;
                r.stego = lsb_insert(it.smp, (k == 2'd0) ? MARK_0 :
                                             (k == 2'd1) ? MARK_1 : MARK_2);
                if (k == 2'd2)
                begin
                    r.marker_done = 1'b1;
                    mark_pos      = 2'd0;
                end
                else
                    mark_pos = k + 2'd1;
            end
            default:
            begin
                b = lsb_gather(it.smp);
                if (held_cnt >= 2'd2)
                begin
                    if (held[0] == MARK_0 && held[1] == MARK_1 && b == MARK_2)
                    begin
                        end_seen      = 1'b1;
                        r.marker_done = 1'b1;
                    end
                    else
                    begin
                        r.out_byte  = held[0];
                        r.out_valid = 1'b1;
                        held[0]     = held[1];
                        held[1]     = b;
                    end
                end
                else
                begin
                    held[held_cnt[0]] = b;
                    held_cnt          = held_cnt + 2'd1;
                end
            end
        endcase
        return r;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic carrier_item_t random_carrier(input logic [1:0] f, input logic [7:0] d);
        carrier_item_t it;
        it.func = f;
        it.data = d;
        for (int i = 0; i < 8; i++)
        begin
            it.smp[i] = 8'($urandom_range(0, 255));
        end
        return it;
    endfunction

    function automatic carrier_item_t extract_carrier(input logic [7:0] b);
        carrier_item_t it;
        it = random_carrier(FUNC_EXTRACT, 8'($urandom));
        it.smp = lsb_insert(it.smp, b);
        return it;
    endfunction

    task automatic report_fault(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // checked away from the rising edge so the driver has settled
    task automatic wait_drained();
        while (carrier_q.size() > 0 || s_axis_tvalid || stego_expect_q.size() > 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // write then read back; only called with the block idle
    task automatic set_capacity(input logic [23:0] val);
        logic [31:0] rd;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {8'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cap_reg = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[23:0] !== val)
            report_fault($sformatf("capacity readback: expected %0h, got %0h", val, rd[23:0]));
    endtask

    // source side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            feed_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                stego_expect_q.push_back(predict_stego(on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap      <= feed_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (carrier_q.size() > 0)
                begin
                    on_bus = carrier_q.pop_front();
                    s_axis_tdata  <= {on_bus.smp, on_bus.data};
                    s_axis_tuser  <= on_bus.func;
                    s_axis_tvalid <= 1'b1;
                    feed_gap      <= idle_len(feed_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            if ($urandom_range(0, 299) == 0)
                feed_calm <= !feed_calm;
        end
    end

    // sink side and result check
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            drain_gap     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (stego_expect_q.size() == 0)
                    report_fault($sformatf("result with nothing expected: tdata %h tuser %b",
                                           m_axis_tdata, m_axis_tuser));
                else
                begin
                    want = stego_expect_q.pop_front();
                    for (int i = 0; i < 8; i++)
                    begin
                        if (m_axis_tdata[8*i +: 8] !== want.stego[i])
                            report_fault($sformatf("stego_%0d: expected %h, got %h", i,
                                                   want.stego[i], m_axis_tdata[8*i +: 8]));
                    end
                    if (m_axis_tdata[71:64] !== want.out_byte)
                        report_fault($sformatf("out_byte: expected %h, got %h",
                                               want.out_byte, m_axis_tdata[71:64]));
                    if (m_axis_tuser[0] !== want.out_valid)
                        report_fault($sformatf("out_valid: expected %b, got %b",
                                               want.out_valid, m_axis_tuser[0]));
                    if (m_axis_tuser[1] !== want.marker_done)
                        report_fault($sformatf("marker_done: expected %b, got %b",
                                               want.marker_done, m_axis_tuser[1]));
                    if (m_axis_tuser[2] !== want.no_room)
                        report_fault($sformatf("no_room: expected %b, got %b",
                                               want.no_room, m_axis_tuser[2]));
                end
            end
            if (drain_gap > 0)
            begin
                drain_gap     <= drain_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    drain_gap <= idle_len(drain_calm);
            end
            if ($urandom_range(0, 299) == 0)
                drain_calm <= !drain_calm;
        end
    end

    initial
    begin
        carrier_item_t it;
        logic [7:0]    ext_seq [7];
        logic [23:0]   cap;
        int            n;
        int            kind;
        int            len;
        int            quota;

        ext_seq = '{8'hFF, MARK_0, MARK_1, 8'h12, MARK_0, MARK_1, 8'h00};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no capacity at all: everything but the unused code reports no room
        set_capacity(24'd0);
        carrier_q.push_back(random_carrier(FUNC_EMBED, 8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_MARK, 8'($urandom)));
        carrier_q.push_back(extract_carrier(8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_UNUSED, 8'($urandom)));
        wait_drained();

        // directed: extremes, marker wrap, interleaved marker, holdback and near misses
        set_capacity(CAP_MAX);
        it = random_carrier(FUNC_EMBED, 8'h00);
        it.smp = {8{8'hFF}};
        carrier_q.push_back(it);
        it = random_carrier(FUNC_EMBED, 8'hFF);
        it.smp = '0;
        carrier_q.push_back(it);
        carrier_q.push_back(random_carrier(FUNC_EMBED, 8'hA5));
        repeat (4) carrier_q.push_back(random_carrier(FUNC_MARK, 8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_EMBED, 8'h5A));
        repeat (2) carrier_q.push_back(random_carrier(FUNC_MARK, 8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_UNUSED, 8'($urandom)));
        it = random_carrier(FUNC_EXTRACT, 8'($urandom));
        it.smp = '0;
        carrier_q.push_back(it);
        foreach (ext_seq[i])
            carrier_q.push_back(extract_carrier(ext_seq[i]));
        it = random_carrier(FUNC_EXTRACT, 8'($urandom));
        it.smp = {8{8'hFF}};
        carrier_q.push_back(it);
        wait_drained();

        // random phases; extract never carries 0xff here so the end marker stays unseen
        for (int p = 0; p < 8; p++)
        begin
            if (p == 3)
                cap = 24'd1;
            else if (p % 2 == 1)
                cap = used_count + 24'($urandom_range(30, 250));
            else
                cap = CAP_MAX;
            set_capacity(cap);
            quota = (p == 3) ? 40 : 235;
            n = 0;
            while (n < quota)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 35)
                begin
                    len = $urandom_range(1, 6);
                    repeat (len) carrier_q.push_back(random_carrier(FUNC_EMBED, 8'($urandom)));
                end
                else if (kind < 55)
                begin
                    // mostly whole three-byte markers, sometimes cut short
                    len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 2) : 3;
                    repeat (len) carrier_q.push_back(random_carrier(FUNC_MARK, 8'($urandom)));
                end
                else if (kind < 92)
                begin
                    len = $urandom_range(1, 8);
                    repeat (len)
                        carrier_q.push_back(extract_carrier(8'($urandom_range(0, 254))));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        carrier_q.push_back(extract_carrier(MARK_0));
                        carrier_q.push_back(extract_carrier(MARK_1));
                        carrier_q.push_back(extract_carrier(8'($urandom_range(0, 254))));
                        len += 3;
                    end
                end
                else
                begin
                    carrier_q.push_back(random_carrier(FUNC_UNUSED, 8'($urandom)));
                    len = 0;
                end
                n += len;
            end
            wait_drained();
        end

        // end marker found, then extract passes through while embed carries on
        set_capacity(CAP_MAX);
        carrier_q.push_back(extract_carrier(8'h31));
        carrier_q.push_back(extract_carrier(MARK_0));
        carrier_q.push_back(extract_carrier(MARK_1));
        carrier_q.push_back(extract_carrier(MARK_2));
        repeat (2) carrier_q.push_back(extract_carrier(8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_EMBED, 8'h3C));
        carrier_q.push_back(random_carrier(FUNC_MARK, 8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_UNUSED, 8'($urandom)));
        wait_drained();

        // after the end, extract wins over lack of room
        set_capacity(24'd0);
        carrier_q.push_back(extract_carrier(8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_EMBED, 8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_MARK, 8'($urandom)));
        carrier_q.push_back(random_carrier(FUNC_UNUSED, 8'($urandom)));
        wait_drained();

        if (mismatches == 0 && stego_expect_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lsbse_pkg.sv
sv/lsbse_cfg.sv
sv/lsbse_core.sv
sv/lsb_stego_embed_extract.sv
test/tb_top.sv
